[hdl/dmwc_pkg.sv]
`timescale 1ns / 1ps

package dmwc_pkg;

    localparam int NUM_LINES_DEF   = 128;
    localparam int BLOCK_BYTES_DEF = 32;

    // fixed field widths of the request and response
    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = 5;
    localparam int BLOCK_W  = 27;
    localparam int INDEX_W  = 7;
    localparam int TAG_W    = 20;
    localparam int COUNT_W  = 32;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic dirty;
    } t_line_flags;

endpackage

[hdl/dmwc_req_if.sv]
`timescale 1ns / 1ps

interface dmwc_req_if;
    logic                        valid;
    logic                        ready;
    logic [dmwc_pkg::ADDR_W-1:0] address;
    logic                        command;

    modport source (output valid, output address, output command, input ready);
    modport sink   (input valid, input address, input command, output ready);
endinterface

[hdl/dmwc_rsp_if.sv]
`timescale 1ns / 1ps

interface dmwc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dmwc_pkg::OFFSET_W-1:0] byte_offset;
    logic [dmwc_pkg::BLOCK_W-1:0]  block_number;
    logic [dmwc_pkg::INDEX_W-1:0]  line_index;
    logic [dmwc_pkg::TAG_W-1:0]    tag;
    logic                          miss;
    logic                          mem_read;
    logic                          mem_write;
    logic                          replacement;
    logic [dmwc_pkg::TAG_W-1:0]    evicted_tag;
    logic [dmwc_pkg::COUNT_W-1:0]  hit_total;
    logic [dmwc_pkg::COUNT_W-1:0]  miss_total;

    modport source (
        output valid, output byte_offset, output block_number, output line_index,
        output tag, output miss, output mem_read, output mem_write,
        output replacement, output evicted_tag, output hit_total, output miss_total,
        input ready
    );
    modport sink (
        input valid, input byte_offset, input block_number, input line_index,
        input tag, input miss, input mem_read, input mem_write,
        input replacement, input evicted_tag, input hit_total, input miss_total,
        output ready
    );
endinterface

[hdl/dmwc_line_store.sv]
`timescale 1ns / 1ps

module dmwc_line_store #(
    parameter int NUM_LINES = dmwc_pkg::NUM_LINES_DEF,
    parameter int IDX_W     = $clog2(NUM_LINES),
    parameter int LTAG_W    = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [IDX_W-1:0]      i_rd_idx,
    input  logic                  i_wr_en,
    input  logic                  i_wr_tag_en,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  logic [LTAG_W-1:0]     i_wr_tag,
    input  dmwc_pkg::t_line_flags i_wr_flags,
    output logic [LTAG_W-1:0]     o_rd_tag,
    output dmwc_pkg::t_line_flags o_rd_flags,
    output logic                  o_busy
);
    import dmwc_pkg::*;

    logic [LTAG_W-1:0] r_tag_mem [NUM_LINES];
    t_line_flags       r_flag_mem [NUM_LINES];

    logic [LTAG_W-1:0] r_rd_tag;
    t_line_flags       r_rd_flags;
    logic              r_fwd;
    logic [LTAG_W-1:0] r_fwd_tag;
    t_line_flags       r_fwd_flags;

    logic              r_clr_busy;
    logic [IDX_W-1:0]  r_clr_idx;

    // flag clearing sweep after reset, one line per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(NUM_LINES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_flag_mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_flag_mem[i_wr_idx] <= i_wr_flags;
        end
        if (i_wr_en && i_wr_tag_en) begin
            r_tag_mem[i_wr_idx] <= i_wr_tag;
        end
    end

    // registered read; a same-cycle write to the read line is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_tag    <= r_tag_mem[i_rd_idx];
            r_rd_flags  <= r_flag_mem[i_rd_idx];
            r_fwd       <= i_wr_en && (i_wr_idx == i_rd_idx);
            r_fwd_tag   <= i_wr_tag;
            r_fwd_flags <= i_wr_flags;
        end
    end

    assign o_rd_tag   = r_fwd ? r_fwd_tag : r_rd_tag;
    assign o_rd_flags = r_fwd ? r_fwd_flags : r_rd_flags;
    assign o_busy     = r_clr_busy;

endmodule

[hdl/direct_mapped_writeback_cache_tags_top.sv]
`timescale 1ns / 1ps
// the tag is read at accept; the lookup result is registered into the response once that is free
// throughput: one request per cycle while the response side keeps up
// reset: synchronous active-low; afterwards a flag clearing sweep over all NUM_LINES
// lines (128 by default) runs and no request is accepted until it ends
// hit and miss counters reset to zero; tag memory is not cleared
module direct_mapped_writeback_cache_tags_top #(
    parameter int NUM_LINES   = dmwc_pkg::NUM_LINES_DEF,
    parameter int BLOCK_BYTES = dmwc_pkg::BLOCK_BYTES_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    dmwc_req_if.sink  i_req,
    dmwc_rsp_if.source o_rsp
);
    import dmwc_pkg::*;

    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int IDX_W  = $clog2(NUM_LINES);
    localparam int LTAG_W = ADDR_W - OFF_W - IDX_W;

    logic              r_s1_vld;
    logic [ADDR_W-1:0] r_s1_addr;
    t_cmd              r_s1_cmd;

    logic               r_o_vld;
    logic [OFFSET_W-1:0] r_o_offset;
    logic [BLOCK_W-1:0] r_o_block;
    logic [INDEX_W-1:0] r_o_index;
    logic [TAG_W-1:0]   r_o_tag;
    logic               r_o_miss;
    logic               r_o_wb;
    logic               r_o_repl;
    logic [TAG_W-1:0]   r_o_evicted;
    logic [COUNT_W-1:0] r_hit_cnt;
    logic [COUNT_W-1:0] r_miss_cnt;

    logic [COUNT_W-1:0] n_hit_cnt;
    logic [COUNT_W-1:0] n_miss_cnt;

    logic              accept;
    logic              s1_adv;
    logic              busy;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  s1_idx;
    logic [LTAG_W-1:0] s1_tag;
    logic [LTAG_W-1:0] old_tag;
    t_line_flags       old_flags;
    t_line_flags       wr_flags;
    logic              miss;
    logic              wb;
    logic              repl;
    logic [ADDR_W-1:0] offset_ext;
    logic [ADDR_W-1:0] block_ext;
    logic [ADDR_W-1:0] index_ext;
    logic [ADDR_W-1:0] tag_ext;
    logic [ADDR_W-1:0] evicted_ext;

    assign s1_adv      = r_s1_vld && (!r_o_vld || o_rsp.ready);
    assign i_req.ready = !busy && (!r_s1_vld || s1_adv);
    assign accept      = i_req.valid && i_req.ready;

    assign rd_idx = i_req.address[OFF_W +: IDX_W];
    assign s1_idx = r_s1_addr[OFF_W +: IDX_W];
    assign s1_tag = r_s1_addr[ADDR_W-1 -: LTAG_W];

    dmwc_line_store #(
        .NUM_LINES (NUM_LINES),
        .IDX_W     (IDX_W),
        .LTAG_W    (LTAG_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_idx    (rd_idx),
        .i_wr_en     (s1_adv),
        .i_wr_tag_en (miss),
        .i_wr_idx    (s1_idx),
        .i_wr_tag    (s1_tag),
        .i_wr_flags  (wr_flags),
        .o_rd_tag    (old_tag),
        .o_rd_flags  (old_flags),
        .o_busy      (busy)
    );

    always_comb begin
        miss           = !(old_flags.valid && (old_tag == s1_tag));
        repl           = miss && old_flags.valid;
        wb             = miss && old_flags.dirty;
        wr_flags.valid = 1'b1;
        // a fill starts clean; a write leaves the line dirty either way
        wr_flags.dirty = (r_s1_cmd == CMD_WRITE) || (!miss && old_flags.dirty);
        n_hit_cnt      = r_hit_cnt + COUNT_W'(!miss);
        n_miss_cnt     = r_miss_cnt + COUNT_W'(miss);
        offset_ext     = ADDR_W'(r_s1_addr[OFF_W-1:0]);
        block_ext      = r_s1_addr >> OFF_W;
        index_ext      = ADDR_W'(s1_idx);
        tag_ext        = ADDR_W'(s1_tag);
        evicted_ext    = repl ? ADDR_W'(old_tag) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_o_vld    <= 1'b0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_o_vld    <= 1'b1;
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
            end else if (o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= i_req.address;
            r_s1_cmd  <= t_cmd'(i_req.command);
        end
        if (s1_adv) begin
            r_o_offset  <= offset_ext[OFFSET_W-1:0];
            r_o_block   <= block_ext[BLOCK_W-1:0];
            r_o_index   <= index_ext[INDEX_W-1:0];
            r_o_tag     <= tag_ext[TAG_W-1:0];
            r_o_miss    <= miss;
            r_o_wb      <= wb;
            r_o_repl    <= repl;
            r_o_evicted <= evicted_ext[TAG_W-1:0];
        end
    end

    assign o_rsp.valid        = r_o_vld;
    assign o_rsp.byte_offset  = r_o_offset;
    assign o_rsp.block_number = r_o_block;
    assign o_rsp.line_index   = r_o_index;
    assign o_rsp.tag          = r_o_tag;
    assign o_rsp.miss         = r_o_miss;
    assign o_rsp.mem_read     = r_o_miss;
    assign o_rsp.mem_write    = r_o_wb;
    assign o_rsp.replacement  = r_o_repl;
    assign o_rsp.evicted_tag  = r_o_evicted;
    assign o_rsp.hit_total    = r_hit_cnt;
    assign o_rsp.miss_total   = r_miss_cnt;

`ifndef SYNTHESIS
    // a dirty line is always valid, so a write-back comes with a replacement
    a_wb_needs_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && wb |-> repl)
        else $error("write-back without replacement");

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !i_req.ready)
        else $error("request accepted during flag clearing");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && !miss |=> r_hit_cnt == $past(r_hit_cnt) + 1'b1)
        else $error("hit counter did not advance on a hit");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |=> r_s1_vld && $stable(r_s1_addr))
        else $error("lookup stage lost its request while stalled");
`endif

endmodule

[tb/dmwc_tag_checker.sv]
`timescale 1ns / 1ps

module dmwc_tag_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dmwc_req_if  i_req,
    dmwc_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_hits,
    output int   o_misses,
    output int   o_writebacks
);
    import dmwc_pkg::*;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [BLOCK_W-1:0]  block_number;
        logic [INDEX_W-1:0]  line_index;
        logic [TAG_W-1:0]    tag;
        logic                miss;
        logic                mem_read;
        logic                mem_write;
        logic                replacement;
        logic [TAG_W-1:0]    evicted_tag;
        logic [COUNT_W-1:0]  hit_total;
        logic [COUNT_W-1:0]  miss_total;
    } t_lookup;

    logic [TAG_W-1:0]   stored_tag [NUM_LINES_DEF];
    logic               line_valid [NUM_LINES_DEF];
    logic               line_dirty [NUM_LINES_DEF];
    logic [COUNT_W-1:0] hit_cnt;
    logic [COUNT_W-1:0] miss_cnt;
    t_lookup            lookup_q [$];

    function automatic t_lookup predict_lookup(input logic [ADDR_W-1:0] addr,
                                               input t_cmd cmd);
        t_lookup     r;
        int unsigned idx;
        r              = '0;
        r.byte_offset  = addr[OFFSET_W-1:0];
        r.block_number = addr[ADDR_W-1:OFFSET_W];
        r.line_index   = addr[OFFSET_W+INDEX_W-1:OFFSET_W];
        r.tag          = addr[ADDR_W-1:OFFSET_W+INDEX_W];
        idx            = r.line_index;
        r.miss         = !(line_valid[idx] && stored_tag[idx] == r.tag);
        if (r.miss) begin
            miss_cnt      = miss_cnt + 1'b1;
            r.mem_read    = 1'b1;
            r.mem_write   = line_dirty[idx];
            r.replacement = line_valid[idx];
            if (line_valid[idx]) begin
                r.evicted_tag = stored_tag[idx];
            end
            // write-allocate: the line is refilled clean, a write dirties it below
            stored_tag[idx] = r.tag;
            line_valid[idx] = 1'b1;
            line_dirty[idx] = 1'b0;
        end else begin
            hit_cnt = hit_cnt + 1'b1;
        end
        if (cmd == CMD_WRITE) begin
            line_dirty[idx] = 1'b1;
        end
        r.hit_total  = hit_cnt;
        r.miss_total = miss_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LINES_DEF; i++) begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
            end
            hit_cnt  = '0;
            miss_cnt = '0;
            lookup_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (lookup_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: response with no request outstanding: expected none, "
                             , $time, "actual block 0x%0h", i_rsp.block_number);
                end else begin
                    want = lookup_q.pop_front();
                    check_field("byte_offset",  want.byte_offset,  i_rsp.byte_offset);
                    check_field("block_number", want.block_number, i_rsp.block_number);
                    check_field("line_index",   want.line_index,   i_rsp.line_index);
                    check_field("tag",          want.tag,          i_rsp.tag);
                    check_field("miss",         want.miss,         i_rsp.miss);
                    check_field("mem_read",     want.mem_read,     i_rsp.mem_read);
                    check_field("mem_write",    want.mem_write,    i_rsp.mem_write);
                    check_field("replacement",  want.replacement,  i_rsp.replacement);
                    check_field("evicted_tag",  want.evicted_tag,  i_rsp.evicted_tag);
                    check_field("hit_total",    want.hit_total,    i_rsp.hit_total);
                    check_field("miss_total",   want.miss_total,   i_rsp.miss_total);
                end
            end
            if (i_req.valid && i_req.ready) begin
                want = predict_lookup(i_req.address, t_cmd'(i_req.command));
                lookup_q.push_back(want);
                if (want.miss) begin
                    o_misses++;
                end else begin
                    o_hits++;
                end
                if (want.mem_write) begin
                    o_writebacks++;
                end
            end
        end
        o_pending = lookup_q.size();
    end

endmodule

[tb/direct_mapped_writeback_cache_tags_top_tb.sv]
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_tags_top_tb;
    import dmwc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RESET_CYCLES   = 11;

    logic i_clk;
    logic i_rst_n;

    dmwc_req_if req_ch ();
    dmwc_rsp_if rsp_ch ();

    int idle_pct;
    int stall_pct;
    int accesses_sent;
    int fail_count;
    int pending;
    int hits;
    int misses;
    int writebacks;

    logic [TAG_W-1:0]  tag_pool [4];
    logic [ADDR_W-1:0] recent_addr [8];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    direct_mapped_writeback_cache_tags_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    dmwc_tag_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_hits       (hits),
        .o_misses     (misses),
        .o_writebacks (writebacks)
    );

    // response back-pressure
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: timeout, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_access(input logic [ADDR_W-1:0] addr, input t_cmd cmd);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.address = addr;
        req_ch.command = cmd;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        accesses_sent++;
    endtask

    // mostly reuse and conflicting tags so hits, evictions and write-backs all show up
    task automatic run_random(input int count);
        logic [ADDR_W-1:0] addr;
        t_cmd              cmd;
        int unsigned       pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                addr                 = recent_addr[$urandom_range(7)];
                addr[OFFSET_W-1:0]   = OFFSET_W'($urandom);
            end else if (pick < 75) begin
                addr = {tag_pool[$urandom_range(3)], INDEX_W'($urandom), OFFSET_W'($urandom)};
            end else begin
                addr = $urandom;
            end
            cmd                            = t_cmd'($urandom_range(1));
            recent_addr[$urandom_range(7)] = addr;
            if ($urandom_range(99) == 0) begin
                tag_pool[$urandom_range(3)] = TAG_W'($urandom);
            end
            send_access(addr, cmd);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.address = '0;
        req_ch.command = CMD_READ;
        foreach (tag_pool[i]) begin
            tag_pool[i] = TAG_W'($urandom);
        end
        foreach (recent_addr[i]) begin
            recent_addr[i] = $urandom;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_pct  = 0;
        stall_pct = 0;
        // cold misses, hits, dirty and clean evictions at both ends of the line range
        send_access(32'h0000_0000, CMD_READ);
        send_access(32'h0000_001F, CMD_WRITE);
        send_access(32'hFFFF_FFFF, CMD_READ);
        send_access(32'hFFFF_FFE0, CMD_WRITE);
        send_access(32'h0000_0FE0, CMD_READ);
        send_access(32'h0000_1000, CMD_READ);
        send_access(32'h0000_0000, CMD_READ);
        send_access(32'hAAAA_AAAA, CMD_WRITE);
        send_access(32'h5555_5555, CMD_READ);
        send_access(32'h5555_5555, CMD_WRITE);
        send_access(32'hAAAA_AAAA, CMD_WRITE);
        // write miss on a clean valid line, then on a dirty one
        send_access(32'h8000_0000, CMD_WRITE);
        send_access(32'h0000_0000, CMD_WRITE);
        send_access(32'h7FFF_FFFF, CMD_READ);
        send_access(32'h7FFF_F000, CMD_READ);
        run_random(490);

        idle_pct  = 48;
        stall_pct = 0;
        run_random(490);

        idle_pct  = 0;
        stall_pct = 48;
        run_random(490);

        idle_pct  = 28;
        stall_pct = 28;
        run_random(480);

        req_ch.valid = 1'b0;
        stall_pct    = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d accesses over four idle/stall mixes: %0d hits, %0d misses, %0d write-backs",
                 accesses_sent, hits, misses, writebacks);
        $display("%0d mismatches found", fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
